// ----- hdl/sobol_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobol generator package
// Beat types, command codes, configuration indexes and fixed field widths.
// ----------------------------------------------------------------------------
package sobol_pkg;

    localparam int PNT_W   = 32;  // point and index width
    localparam int DEG_W   = 5;   // polynomial degree width
    localparam int COEF_W  = 17;  // inner coefficient bits
    localparam int IVAL_W  = 18;  // initial direction integer width
    localparam int IIDX_W  = 5;   // initial value position width
    localparam int CMD_W   = 2;
    localparam int CFGI_W  = 2;   // configuration register index width
    localparam int CFGD_W  = 32;  // configuration write data width
    localparam int XW      = 6;   // width for table index arithmetic

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

    localparam logic [CFGI_W-1:0] CFG_POLY_DEGREE = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_POLY_COEFFS = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_FIRST_DIM   = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_POINT_COUNT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IIDX_W-1:0] init_index;
        logic [IVAL_W-1:0] init_value;
    } t_in;

    typedef struct packed {
        logic [PNT_W-1:0] point;
        logic [PNT_W-1:0] point_index;
        logic             last_point;
        logic             exhausted;
    } t_out;

    typedef struct packed {
        logic [DEG_W-1:0]  poly_degree;
        logic [COEF_W-1:0] poly_coeffs;
        logic              first_dimension;
        logic [PNT_W-1:0]  point_count;
    } t_cfg;

endpackage

// ----- hdl/sobol_core.sv -----
// ----------------------------------------------------------------------------
// Sobol core
// Sequencer, initial value and direction number memories, point and index.
// ----------------------------------------------------------------------------
module sobol_core #(
    parameter int MAX_DEGREE = 18,
    parameter int POINT_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sobol_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  sobol_pkg::t_in    i_in,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output sobol_pkg::t_out   o_res
);

    localparam int IAW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DAW = $clog2(POINT_BITS);
    localparam int IW  = $clog2(POINT_BITS + 1);
    localparam int KW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int XW  = sobol_pkg::XW;
    localparam int PW  = sobol_pkg::PNT_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_B_ISSUE = 3'd1;
    localparam logic [2:0] ST_B_ACC   = 3'd2;
    localparam logic [2:0] ST_B_WRITE = 3'd3;
    localparam logic [2:0] ST_N_XOR   = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_i, n_i;
    logic [KW-1:0] r_k, n_k;
    logic [PW-1:0] r_acc, n_acc;
    logic [PW-1:0] r_point, n_point;
    logic [PW-1:0] r_counter, n_counter;
    logic          r_exh, n_exh;

    logic [sobol_pkg::IVAL_W-1:0] init_mem [0:MAX_DEGREE-1];
    logic [sobol_pkg::IVAL_W-1:0] r_init_q;
    logic [PW-1:0]                dir_mem [0:POINT_BITS-1];
    logic [PW-1:0]                r_dir_q;

    logic           init_we;
    logic [IAW-1:0] init_wa, init_ra;
    logic           dir_we;
    logic [DAW-1:0] dir_wa, dir_ra;

    logic [sobol_pkg::DEG_W-1:0] deg;
    logic [XW-1:0] i6, k6, s6, base_a, term_a, coef_sel, tone;
    logic [4:0]    sh_left;
    logic [PW-1:0] coef_ext;
    logic          use_init, k_last, coef_bit, load_ok;

    // Effective degree: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (i_cfg.poly_degree == '0) begin
            deg = sobol_pkg::DEG_W'(1);
        end else if (i_cfg.poly_degree > sobol_pkg::DEG_W'(MAX_DEGREE)) begin
            deg = sobol_pkg::DEG_W'(MAX_DEGREE);
        end else begin
            deg = i_cfg.poly_degree;
        end
    end

    // Trailing ones of the index: the first zero bit from the bottom.
    always_comb begin
        tone = XW'(PW);
        for (int n = PW - 1; n >= 0; n--) begin
            if (!r_counter[n]) begin
                tone = XW'(n);
            end
        end
    end

    assign i6       = XW'(r_i);
    assign k6       = XW'(r_k);
    assign s6       = XW'(deg);
    assign base_a   = i6 - s6 - XW'(1);
    assign term_a   = i6 - k6 - XW'(1);
    assign coef_sel = s6 - XW'(1) - k6;
    assign coef_ext = PW'(i_cfg.poly_coeffs);
    assign coef_bit = coef_ext[coef_sel[4:0]];
    assign sh_left  = 5'(XW'(PW) - i6);
    assign use_init = (i6 <= s6);
    assign k_last   = (k6 == s6 - XW'(1));
    assign load_ok  = (i_in.init_index != '0) &&
                      (i_in.init_index <= sobol_pkg::IIDX_W'(MAX_DEGREE));

    assign init_we = (r_state == ST_IDLE) && i_valid && (i_in.cmd == sobol_pkg::CMD_LOAD)
                     && load_ok;
    assign init_wa = IAW'(i_in.init_index - sobol_pkg::IIDX_W'(1));
    assign init_ra = IAW'(i6 - XW'(1));
    assign dir_we  = (r_state == ST_B_WRITE);
    assign dir_wa  = DAW'(i6 - XW'(1));
    assign dir_ra  = (r_state == ST_IDLE) ? DAW'(tone) :
                     (r_k == '0)          ? DAW'(base_a) : DAW'(term_a);

    always_ff @(posedge i_clk) begin
        if (init_we) begin
            init_mem[init_wa] <= i_in.init_value;
        end
        r_init_q <= init_mem[init_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_wa] <= r_acc;
        end
        r_dir_q <= dir_mem[dir_ra];
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_k       = r_k;
        n_acc     = r_acc;
        n_point   = r_point;
        n_counter = r_counter;
        n_exh     = r_exh;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_in.cmd)
                        sobol_pkg::CMD_RESTART: begin
                            n_i     = IW'(1);
                            n_k     = '0;
                            n_state = ST_B_ISSUE;
                        end
                        sobol_pkg::CMD_NEXT: begin
                            if (tone >= XW'(POINT_BITS)) begin
                                n_exh   = 1'b1;
                                n_state = ST_EMIT;
                            end else begin
                                n_exh   = 1'b0;
                                n_state = ST_N_XOR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_B_ISSUE: begin
                if (i_cfg.first_dimension) begin
                    n_acc   = PW'(1) << sh_left;
                    n_state = ST_B_WRITE;
                end else if (use_init || r_k == '0 || coef_bit) begin
                    n_state = ST_B_ACC;
                end else if (k_last) begin
                    n_state = ST_B_WRITE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            ST_B_ACC: begin
                if (use_init) begin
                    n_acc   = PW'(r_init_q) << sh_left;
                    n_state = ST_B_WRITE;
                end else begin
                    if (r_k == '0) begin
                        n_acc = r_dir_q ^ (r_dir_q >> deg);
                    end else begin
                        n_acc = r_acc ^ r_dir_q;
                    end
                    if (k_last) begin
                        n_state = ST_B_WRITE;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = ST_B_ISSUE;
                    end
                end
            end
            ST_B_WRITE: begin
                if (r_i == IW'(POINT_BITS)) begin
                    n_point   = '0;
                    n_counter = '0;
                    n_exh     = 1'b0;
                    n_state   = ST_EMIT;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_k     = '0;
                    n_state = ST_B_ISSUE;
                end
            end
            ST_N_XOR: begin
                n_point   = r_point ^ r_dir_q;
                n_counter = r_counter + PW'(1);
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_point   <= '0;
            r_counter <= '0;
            r_exh     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_point   <= n_point;
            r_counter <= n_counter;
            r_exh     <= n_exh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_k   <= n_k;
        r_acc <= n_acc;
    end

    assign o_ready           = (r_state == ST_IDLE);
    assign o_res_valid       = (r_state == ST_EMIT);
    assign o_res.point       = r_point;
    assign o_res.point_index = r_counter;
    assign o_res.last_point  = (r_counter == i_cfg.point_count - PW'(1));
    assign o_res.exhausted   = r_exh;

    // An exhausted beat is only possible with every usable index bit set.
    a_exh_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.exhausted |-> &r_counter[POINT_BITS-1:0])
        else $error("exhausted beat with a usable trailing-ones count");

    a_next_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_N_XOR |=> r_counter == $past(r_counter) + PW'(1))
        else $error("index did not advance on a next step");

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_B_WRITE && r_i == IW'(POINT_BITS)
        |=> r_state == ST_EMIT && r_point == '0 && r_counter == '0)
        else $error("restart did not give point zero");

    a_build_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_B_ISSUE |-> r_i != '0 && r_i <= IW'(POINT_BITS) && k6 < s6)
        else $error("table build index out of range");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(r_counter))
        else $error("result dropped before it was taken");

endmodule

// ----- hdl/sobol_sequence_generator.sv -----
// ----------------------------------------------------------------------------
// Sobol sequence generator
// One dimension of a Sobol sequence in Gray-code order, 0.32 fixed point.
// ----------------------------------------------------------------------------
// Load: written to the initial value memory on acceptance, no beat out. Next:
// beat registered through the xor and emit states, set by the registered
// direction memory read. Restart: rebuilds the POINT_BITS direction numbers,
// directly in first-dimension mode and otherwise with one direction memory
// read per term, and ends in a beat of point zero. One item at a time; a
// result waiting in the output register holds back only the core's next beat.
// Synchronous active-low reset clears control, point and index; memories keep
// their contents and are valid only once written.
module sobol_sequence_generator #(
    parameter int MAX_DEGREE = 18,
    parameter int POINT_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sobol_pkg::t_in                     i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sobol_pkg::t_out                    o_out,
    input  logic                               i_cfg_we,
    input  logic [sobol_pkg::CFGI_W-1:0]       i_cfg_index,
    input  logic [sobol_pkg::CFGD_W-1:0]       i_cfg_data
);

    sobol_pkg::t_cfg r_cfg;
    sobol_pkg::t_out core_res;
    sobol_pkg::t_out r_out;
    logic            r_out_valid;
    logic            core_valid;
    logic            core_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly_degree     <= sobol_pkg::DEG_W'(1);
            r_cfg.poly_coeffs     <= '0;
            r_cfg.first_dimension <= 1'b1;
            r_cfg.point_count     <= sobol_pkg::PNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sobol_pkg::CFG_POLY_DEGREE:
                    r_cfg.poly_degree <= i_cfg_data[sobol_pkg::DEG_W-1:0];
                sobol_pkg::CFG_POLY_COEFFS:
                    r_cfg.poly_coeffs <= i_cfg_data[sobol_pkg::COEF_W-1:0];
                sobol_pkg::CFG_FIRST_DIM:
                    r_cfg.first_dimension <= i_cfg_data[0];
                sobol_pkg::CFG_POINT_COUNT:
                    r_cfg.point_count <= i_cfg_data[sobol_pkg::PNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sobol_core #(
        .MAX_DEGREE (MAX_DEGREE),
        .POINT_BITS (POINT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (core_valid),
        .i_res_ready (core_take),
        .o_res       (core_res)
    );

    // The output register frees the core as soon as the beat is copied.
    assign core_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_take) begin
            r_out_valid <= core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_take && core_valid) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
